// File: src/cpsat_pkg.sv
// -----------------------------------------------------------------------------
// cpsat_pkg: shared types and constants for the SAT polygon collision core
// Holds the sizing, the command codes, the arithmetic types and the control
// word that the sequencer hands to the projection unit.
// -----------------------------------------------------------------------------
package cpsat_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int COORD_BITS   = 16;

   localparam int IDX_W   = $clog2(MAX_VERTICES);
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W  = IDX_W + 1;
   localparam int ENTRY_W = 2 * COORD_BITS;
   localparam int WORLD_W = COORD_BITS + 1;
   localparam int PROD_W  = 2 * WORLD_W;
   localparam int DOT_W   = PROD_W + 1;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_POS  = 2'd1;
   localparam logic [1:0] CMD_EVAL = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [WORLD_W-1:0]    world_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [DOT_W-1:0]      dot_type;

   typedef struct packed {
      logic latch_vi;   // capture edge start vertex from the RAM
      logic make_axis;  // form (-dy, dx) from start vertex and RAM data
      logic make_world; // add polygon position to RAM data
      logic mul_en;     // run the shared multiplier
      logic mul_y;      // multiplier takes the y operands
      logic acc_load;   // park the x product
      logic sum_en;     // add the two products into the dot product
      logic minmax_en;  // fold the dot product into the interval
      logic first;      // first vertex of the polygon on this axis
      logic poly;       // polygon whose interval is updated
   } ctrl_type;

   // Wrap a 16-bit signed coordinate to COORD_BITS
   function automatic coord_type to_coord(input logic signed [15:0] raw);
      return coord_type'(raw);
   endfunction

endpackage

// File: src/cpsat_vram.sv
// -----------------------------------------------------------------------------
// cpsat_vram: vertex store
// One write port, one read port with registered read data. Entry holds
// {y, x}; the address is {polygon, vertex index}.
// -----------------------------------------------------------------------------
module cpsat_vram (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [cpsat_pkg::ADDR_W-1:0]        wr_addr,
   input  logic [cpsat_pkg::ENTRY_W-1:0]       wr_data,
   input  logic [cpsat_pkg::ADDR_W-1:0]        rd_addr,
   output logic [cpsat_pkg::ENTRY_W-1:0]       rd_data
);

   logic [cpsat_pkg::ENTRY_W-1:0] ram_ff [2**cpsat_pkg::ADDR_W];
   logic [cpsat_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/cpsat_proj.sv
// -----------------------------------------------------------------------------
// cpsat_proj: projection unit
// Builds the edge axis, the world vertex and its dot product with the axis
// through one shared multiplier, and keeps both polygons' intervals.
// -----------------------------------------------------------------------------
module cpsat_proj (
   input  logic                            clock,
   input  cpsat_pkg::ctrl_type             ctrl,
   input  logic [cpsat_pkg::ENTRY_W-1:0]   rd_data,
   input  cpsat_pkg::coord_type            pos_x,
   input  cpsat_pkg::coord_type            pos_y,
   output logic                            gap
);

   cpsat_pkg::coord_type rx, ry;
   cpsat_pkg::coord_type vix_ff, viy_ff;
   cpsat_pkg::world_type ax_ff, ay_ff, wx_ff, wy_ff;
   cpsat_pkg::world_type mul_a, mul_b;
   cpsat_pkg::prod_type  prod_in, prod_ff;
   cpsat_pkg::dot_type   acc_ff, dot_ff;
   cpsat_pkg::dot_type   alo_ff, ahi_ff, blo_ff, bhi_ff;
   cpsat_pkg::dot_type   lo_cur, hi_cur;

   assign rx = cpsat_pkg::coord_type'(rd_data[cpsat_pkg::COORD_BITS-1:0]);
   assign ry = cpsat_pkg::coord_type'(rd_data[cpsat_pkg::ENTRY_W-1:cpsat_pkg::COORD_BITS]);

   // shared multiplier operand select
   assign mul_a   = ctrl.mul_y ? wy_ff : wx_ff;
   assign mul_b   = ctrl.mul_y ? ay_ff : ax_ff;
   assign prod_in = cpsat_pkg::prod_type'(mul_a) * cpsat_pkg::prod_type'(mul_b);

   assign lo_cur = ctrl.poly ? blo_ff : alo_ff;
   assign hi_cur = ctrl.poly ? bhi_ff : ahi_ff;

   always_ff @(posedge clock) begin
      if (ctrl.latch_vi) begin
         vix_ff <= rx;
         viy_ff <= ry;
      end
      if (ctrl.make_axis) begin
         ax_ff <= cpsat_pkg::world_type'(viy_ff) - cpsat_pkg::world_type'(ry);
         ay_ff <= cpsat_pkg::world_type'(rx) - cpsat_pkg::world_type'(vix_ff);
      end
      if (ctrl.make_world) begin
         wx_ff <= cpsat_pkg::world_type'(rx) + cpsat_pkg::world_type'(pos_x);
         wy_ff <= cpsat_pkg::world_type'(ry) + cpsat_pkg::world_type'(pos_y);
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc_load) begin
         acc_ff <= cpsat_pkg::dot_type'(prod_ff);
      end
      if (ctrl.sum_en) begin
         dot_ff <= acc_ff + cpsat_pkg::dot_type'(prod_ff);
      end
      if (ctrl.minmax_en) begin
         if (ctrl.first || dot_ff < lo_cur) begin
            if (ctrl.poly) begin
               blo_ff <= dot_ff;
            end else begin
               alo_ff <= dot_ff;
            end
         end
         if (ctrl.first || dot_ff > hi_cur) begin
            if (ctrl.poly) begin
               bhi_ff <= dot_ff;
            end else begin
               ahi_ff <= dot_ff;
            end
         end
      end
   end

   assign gap = (ahi_ff < blo_ff) || (bhi_ff < alo_ff);

endmodule

// File: src/convex_polygon_sat_collision_core.sv
// -----------------------------------------------------------------------------
// convex_polygon_sat_collision_core: 2-D convex polygon collision test
// Collects two convex polygons (A and B) as vertices relative to a center
// plus one position each, and on evaluate runs the separating axis test with
// exact integer dot products. Load and position words are taken one per cycle
// and give no result. An evaluate word gives one result word {dropped,
// collide} and then clears both polygons, both positions and the drop flag.
// An evaluate tests no axis when either polygon is empty. Otherwise its run,
// plus the wait for the result register, is set by the single read port of
// the vertex RAM and the one shared multiplier: every edge costs two RAM
// reads for its axis and a gap check, and every vertex on every axis costs
// six steps (read, world add, two multiplies, sum, min/max). The core takes
// no word while it evaluates; the test stops at the first separating axis.
// Each polygon holds MAX_VERTICES vertices; further vertices are dropped and
// reported through dropped.
// -----------------------------------------------------------------------------
module convex_polygon_sat_collision_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] coord_x, [31:16] coord_y
   input  logic [2:0]  req_tuser,   // [1:0] cmd, [2] poly_sel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] collide, [1] dropped, [7:2] zero
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_START  = 13'b0000000000010,
      S_EDGE_I = 13'b0000000000100,
      S_EDGE_J = 13'b0000000001000,
      S_AXIS   = 13'b0000000010000,
      S_VREAD  = 13'b0000000100000,
      S_WORLD  = 13'b0000001000000,
      S_MULX   = 13'b0000010000000,
      S_MULY   = 13'b0000100000000,
      S_SUM    = 13'b0001000000000,
      S_MINMAX = 13'b0010000000000,
      S_GAP    = 13'b0100000000000,
      S_RESULT = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // sequencer indexes: p/i walk the edges, q/k walk the projected vertices
   logic                          p_ff, p_in, q_ff, q_in;
   logic [cpsat_pkg::IDX_W-1:0]   i_ff, i_in, k_ff, k_in, j_idx;
   logic                          verdict_ff, verdict_in;
   logic                          finish;

   logic [cpsat_pkg::CNT_W-1:0]   cnt_ff [2];
   cpsat_pkg::coord_type          pos_x_ff [2];
   cpsat_pkg::coord_type          pos_y_ff [2];
   logic                          drop_ff;

   logic                          rsp_valid_ff, rsp_collide_ff, rsp_dropped_ff;

   logic                          req_fire;
   logic [1:0]                    cmd;
   logic                          sel;
   cpsat_pkg::coord_type          cx, cy;
   logic [cpsat_pkg::CNT_W-1:0]   cnt_req, n_p, n_q;
   logic                          room, last_i, last_k;

   logic                          wr_en;
   logic [cpsat_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
   logic [cpsat_pkg::ENTRY_W-1:0] wr_data, rd_data;

   cpsat_pkg::ctrl_type           ctrl;
   cpsat_pkg::coord_type          pos_x_q, pos_y_q;
   logic                          gap;

   // ---- input decode ----
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign cmd        = req_tuser[1:0];
   assign sel        = req_tuser[2];
   assign cx         = cpsat_pkg::to_coord(req_tdata[15:0]);
   assign cy         = cpsat_pkg::to_coord(req_tdata[31:16]);

   assign cnt_req = sel ? cnt_ff[1] : cnt_ff[0];
   assign room    = cnt_req < cpsat_pkg::CNT_W'(cpsat_pkg::MAX_VERTICES);

   // append the vertex at the polygon's fill count
   assign wr_en   = req_fire && (cmd == cpsat_pkg::CMD_LOAD) && room;
   assign wr_addr = {sel, cnt_req[cpsat_pkg::IDX_W-1:0]};
   assign wr_data = {cy, cx};

   // ---- loop bounds ----
   assign n_p    = p_ff ? cnt_ff[1] : cnt_ff[0];
   assign n_q    = q_ff ? cnt_ff[1] : cnt_ff[0];
   assign last_i = (cpsat_pkg::CNT_W'(i_ff) + cpsat_pkg::CNT_W'(1)) == n_p;
   assign last_k = (cpsat_pkg::CNT_W'(k_ff) + cpsat_pkg::CNT_W'(1)) == n_q;
   // wrap the closing edge back to the first vertex
   assign j_idx  = last_i ? '0 : i_ff + cpsat_pkg::IDX_W'(1);

   assign pos_x_q = q_ff ? pos_x_ff[1] : pos_x_ff[0];
   assign pos_y_q = q_ff ? pos_y_ff[1] : pos_y_ff[0];

   // ---- sequencer ----
   always_comb begin
      state_in   = state_ff;
      p_in       = p_ff;
      i_in       = i_ff;
      q_in       = q_ff;
      k_in       = k_ff;
      verdict_in = verdict_ff;
      finish     = 1'b0;
      ctrl       = '0;
      ctrl.poly  = q_ff;
      ctrl.first = (k_ff == '0);
      rd_addr    = {q_ff, k_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_fire && cmd == cpsat_pkg::CMD_EVAL) begin
               state_in = S_START;
            end
         end
         S_START: begin
            // empty polygons settle the answer without any axis
            if (cnt_ff[0] == '0 && cnt_ff[1] == '0) begin
               verdict_in = 1'b1;
               state_in   = S_RESULT;
            end else if (cnt_ff[0] == '0 || cnt_ff[1] == '0) begin
               verdict_in = 1'b0;
               state_in   = S_RESULT;
            end else begin
               p_in     = 1'b0;
               i_in     = '0;
               state_in = S_EDGE_I;
            end
         end
         S_EDGE_I: begin
            rd_addr  = {p_ff, i_ff};
            state_in = S_EDGE_J;
         end
         S_EDGE_J: begin
            rd_addr       = {p_ff, j_idx};
            ctrl.latch_vi = 1'b1;
            state_in      = S_AXIS;
         end
         S_AXIS: begin
            ctrl.make_axis = 1'b1;
            q_in           = 1'b0;
            k_in           = '0;
            state_in       = S_VREAD;
         end
         S_VREAD: begin
            state_in = S_WORLD;
         end
         S_WORLD: begin
            ctrl.make_world = 1'b1;
            state_in        = S_MULX;
         end
         S_MULX: begin
            ctrl.mul_en = 1'b1;
            state_in    = S_MULY;
         end
         S_MULY: begin
            ctrl.mul_en   = 1'b1;
            ctrl.mul_y    = 1'b1;
            ctrl.acc_load = 1'b1;
            state_in      = S_SUM;
         end
         S_SUM: begin
            ctrl.sum_en = 1'b1;
            state_in    = S_MINMAX;
         end
         S_MINMAX: begin
            ctrl.minmax_en = 1'b1;
            if (!last_k) begin
               k_in     = k_ff + cpsat_pkg::IDX_W'(1);
               state_in = S_VREAD;
            end else if (!q_ff) begin
               q_in     = 1'b1;
               k_in     = '0;
               state_in = S_VREAD;
            end else begin
               state_in = S_GAP;
            end
         end
         S_GAP: begin
            // stop at the first separating axis
            if (gap) begin
               verdict_in = 1'b0;
               state_in   = S_RESULT;
            end else if (!last_i) begin
               i_in     = i_ff + cpsat_pkg::IDX_W'(1);
               state_in = S_EDGE_I;
            end else if (!p_ff) begin
               p_in     = 1'b1;
               i_in     = '0;
               state_in = S_EDGE_I;
            end else begin
               verdict_in = 1'b1;
               state_in   = S_RESULT;
            end
         end
         S_RESULT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---- control state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         pos_x_ff[0]  <= '0;
         pos_x_ff[1]  <= '0;
         pos_y_ff[0]  <= '0;
         pos_y_ff[1]  <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            // clear both polygons once the result is issued
            cnt_ff[0]   <= '0;
            cnt_ff[1]   <= '0;
            pos_x_ff[0] <= '0;
            pos_x_ff[1] <= '0;
            pos_y_ff[0] <= '0;
            pos_y_ff[1] <= '0;
            drop_ff     <= 1'b0;
         end else if (req_fire && cmd == cpsat_pkg::CMD_LOAD) begin
            if (room) begin
               cnt_ff[sel] <= cnt_req + cpsat_pkg::CNT_W'(1);
            end else begin
               drop_ff <= 1'b1;
            end
         end else if (req_fire && cmd == cpsat_pkg::CMD_POS) begin
            pos_x_ff[sel] <= cx;
            pos_y_ff[sel] <= cy;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- sequencer indexes and result payload ----
   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      i_ff       <= i_in;
      q_ff       <= q_in;
      k_ff       <= k_in;
      verdict_ff <= verdict_in;
      if (finish) begin
         rsp_collide_ff <= verdict_ff;
         rsp_dropped_ff <= drop_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_dropped_ff, rsp_collide_ff};

   cpsat_vram u_vram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cpsat_proj u_proj (
      .clock   (clock),
      .ctrl    (ctrl),
      .rd_data (rd_data),
      .pos_x   (pos_x_q),
      .pos_y   (pos_y_q),
      .gap     (gap)
   );

endmodule

// File: src/cpsat_check.sv
// -----------------------------------------------------------------------------
// cpsat_check: port-level checks for the SAT polygon collision core
// Watches the request and response streams and flags protocol or sequencing
// slips.
// -----------------------------------------------------------------------------
module cpsat_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // padding bits of the result stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:2] == 6'b0)
      else $error("result padding not zero");

   // an evaluate makes the core busy
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser[1:0] == cpsat_pkg::CMD_EVAL |=> !req_tready)
      else $error("ready after evaluate");

   // load, position and unused words keep the core ready
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser[1:0] != cpsat_pkg::CMD_EVAL |=> req_tready)
      else $error("core busy after a non-evaluate word");

   // a new result only appears at the end of a busy evaluate
   a_rsp_after_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without evaluate");

endmodule

bind convex_polygon_sat_collision_core cpsat_check u_cpsat_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: test/tb.sv
// -----------------------------------------------------------------------------
// tb: self-checking bench for convex_polygon_sat_collision_core
// Drives load, position, evaluate and spare words into the core and predicts
// each evaluate result with its own separating axis test on exact integer
// dot products. Results are matched in order against the predicted
// {dropped, collide} pairs. Both sides idle at random, and once the result
// side holds off long enough to back the core up into its input.
// -----------------------------------------------------------------------------
module tb;

   // spare command code: the core must ignore it
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam logic       POLY_A    = 1'b0;
   localparam logic       POLY_B    = 1'b1;

   localparam int ITEM_TARGET  = 1700;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 100;
   // Even if every third word were an evaluate of two full polygons behind the
   // longest stalls, this is ample.
   localparam int LIMIT_CYCLES = 4_000_000;

   // ---------------------------------------------------------------------------
   // Predictor and store of expected {dropped, collide} pairs
   // ---------------------------------------------------------------------------
   class collision_scoreboard;
      cpsat_pkg::coord_type vert_x[2][cpsat_pkg::MAX_VERTICES];
      cpsat_pkg::coord_type vert_y[2][cpsat_pkg::MAX_VERTICES];
      int                   count[2];
      cpsat_pkg::coord_type pos_x[2];
      cpsat_pkg::coord_type pos_y[2];
      bit                   dropped;
      bit [1:0]             expected_q[$];   // [0] collide, [1] dropped
      int                   errors;
      int                   evals;
      int                   hits;
      int                   drops;
      int                   results;

      function new();
         clear_polygons();
      endfunction

      function void clear_polygons();
         for (int p = 0; p < 2; p++) begin
            count[p] = 0;
            pos_x[p] = '0;
            pos_y[p] = '0;
         end
         dropped = 1'b0;
      endfunction

      // project the world vertices of polygon p onto (ax, ay)
      function void span(int p, longint ax, longint ay,
                         output longint lo, output longint hi);
         longint wx, wy, d;
         for (int i = 0; i < count[p]; i++) begin
            wx = longint'(vert_x[p][i]) + longint'(pos_x[p]);
            wy = longint'(vert_y[p][i]) + longint'(pos_y[p]);
            d  = wx * ax + wy * ay;
            if (i == 0 || d < lo) lo = d;
            if (i == 0 || d > hi) hi = d;
         end
      endfunction

      function bit polygons_touch();
         int     n, j;
         longint dx, dy;
         longint lo[2];
         longint hi[2];
         if (count[0] == 0 && count[1] == 0) return 1'b1;
         if (count[0] == 0 || count[1] == 0) return 1'b0;
         for (int p = 0; p < 2; p++) begin
            n = count[p];
            for (int i = 0; i < n; i++) begin
               j  = (i + 1 == n) ? 0 : i + 1;
               dx = longint'(vert_x[p][j]) - longint'(vert_x[p][i]);
               dy = longint'(vert_y[p][j]) - longint'(vert_y[p][i]);
               span(0, -dy, dx, lo[0], hi[0]);
               span(1, -dy, dx, lo[1], hi[1]);
               if (hi[0] < lo[1] || hi[1] < lo[0]) return 1'b0;
            end
         end
         return 1'b1;
      endfunction

      function void note_word(logic [1:0] cmd, logic sel,
                              logic [15:0] raw_x, logic [15:0] raw_y);
         cpsat_pkg::coord_type x, y;
         bit                   touch;
         x = cpsat_pkg::coord_type'(signed'(raw_x));
         y = cpsat_pkg::coord_type'(signed'(raw_y));
         case (cmd)
            cpsat_pkg::CMD_LOAD: begin
               if (count[sel] < cpsat_pkg::MAX_VERTICES) begin
                  vert_x[sel][count[sel]] = x;
                  vert_y[sel][count[sel]] = y;
                  count[sel]++;
               end else begin
                  dropped = 1'b1;
               end
            end
            cpsat_pkg::CMD_POS: begin
               pos_x[sel] = x;
               pos_y[sel] = y;
            end
            cpsat_pkg::CMD_EVAL: begin
               touch = polygons_touch();
               expected_q.insert(expected_q.size(), {dropped, touch});
               evals++;
               hits  += touch;
               drops += dropped;
               clear_polygons();
            end
            default: ;
         endcase
      endfunction

      function void check_word(logic collide, logic drop);
         bit [1:0] want;
         results++;
         if (expected_q.size() == 0) begin
            $error("result with no evaluate pending: collide %0d dropped %0d",
                   collide, drop);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (collide !== want[0]) begin
            $error("collide: expected %0d, actual %0d", want[0], collide);
            errors++;
         end
         if (drop !== want[1]) begin
            $error("dropped: expected %0d, actual %0d", want[1], drop);
            errors++;
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // Clock, reset and block
   // ---------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [15:0] coord_x, [31:16] coord_y
   logic [2:0]  req_tuser  = '0;   // [1:0] cmd, [2] poly_sel
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] collide, [1] dropped, [7:2] zero

   collision_scoreboard sb = new();

   int unsigned cycles     = 0;
   int          sent_words = 0;
   int          req_quiet  = 0;
   int          rsp_quiet  = 0;
   bit          held_off   = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   convex_polygon_sat_collision_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Hard stop in case the core hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------------------

   // Offer one word after a random gap, hold it until taken, then log it.
   // Valid is only touched once per edge: lowered for a gap, or raised.
   task automatic send_word(logic [1:0] cmd, logic sel,
                            logic [15:0] x, logic [15:0] y);
      int gap;
      if (req_quiet > 0) begin
         req_quiet--;
         gap = 0;
      end else begin
         // now and then, run a stretch back to back
         if ($urandom_range(0, 39) == 0) req_quiet = $urandom_range(20, 60);
         gap = $urandom_range(0, 13);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tuser  <= {sel, cmd};
      do @(posedge clock); while (!req_tready);
      sb.note_word(cmd, sel, x, y);
      if (cmd != CMD_SPARE) sent_words++;
   endtask

   // Random coordinate within +/- spread, or any 16-bit pattern at full scale
   function automatic logic [15:0] rand_coord(int spread);
      if (spread >= 32767) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 2 * spread) - spread);
   endfunction

   // One well-formed evaluate: optional positions, interleaved vertex loads
   // for both polygons, the odd spare word, then evaluate
   task automatic run_pair();
      int          spread, n_a, n_b, base_x, base_y;
      logic        sel;
      logic [15:0] bx, by;
      case ($urandom_range(0, 3))
         0: spread = 16;
         1: spread = 256;
         2: spread = 4096;
         default: spread = 32767;
      endcase
      // mostly small polygons; keep full ones rare since evaluate is quadratic
      n_a = ($urandom_range(0, 14) == 0)
            ? $urandom_range(10, cpsat_pkg::MAX_VERTICES + 3)
            : $urandom_range(0, 6);
      n_b = ($urandom_range(0, 14) == 0)
            ? $urandom_range(10, cpsat_pkg::MAX_VERTICES + 3)
            : $urandom_range(0, 6);
      base_x = $urandom_range(0, 4000) - 2000;
      base_y = $urandom_range(0, 4000) - 2000;
      if ($urandom_range(0, 3) != 0)
         send_word(cpsat_pkg::CMD_POS, POLY_A, 16'(base_x), 16'(base_y));
      while (n_a + n_b > 0) begin
         sel = (n_b == 0) ? POLY_A :
               (n_a == 0) ? POLY_B : 1'($urandom_range(0, 1));
         if (sel == POLY_A) n_a--; else n_b--;
         send_word(cpsat_pkg::CMD_LOAD, sel, rand_coord(spread), rand_coord(spread));
         if ($urandom_range(0, 29) == 0)
            send_word(CMD_SPARE, 1'($urandom_range(0, 1)),
                      rand_coord(32767), rand_coord(32767));
      end
      // place B near A most of the time so both outcomes show up
      if ($urandom_range(0, 3) != 0) begin
         if ($urandom_range(0, 4) == 0) begin
            bx = rand_coord(32767);
            by = rand_coord(32767);
         end else begin
            bx = 16'(base_x + $urandom_range(0, 4 * spread) - 2 * spread);
            by = 16'(base_y + $urandom_range(0, 4 * spread) - 2 * spread);
         end
         send_word(cpsat_pkg::CMD_POS, POLY_B, bx, by);
      end
      send_word(cpsat_pkg::CMD_EVAL, 1'($urandom_range(0, 1)),
                rand_coord(32767), rand_coord(32767));
   endtask

   // Any command, any polygon, any coordinates
   task automatic run_noise();
      repeat ($urandom_range(1, 4))
         send_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   rand_coord(32767), rand_coord(32767));
   endtask

   // ---------------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------------
   initial begin : result_side
      int w;
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && sb.evals >= 15) begin
            // long hold-off: the core fills and must stall its input
            held_off = 1'b1;
            w = HOLD_CYCLES;
         end else if (rsp_quiet > 0) begin
            rsp_quiet--;
            w = 0;
         end else begin
            if ($urandom_range(0, 19) == 0) rsp_quiet = $urandom_range(5, 20);
            w = $urandom_range(0, 13);
         end
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_word(rsp_tdata[0], rsp_tdata[1]);
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // both polygons empty: collide
      send_word(cpsat_pkg::CMD_EVAL, POLY_A, 16'h0000, 16'h0000);
      // spare command is ignored, then A alone: no collision
      send_word(CMD_SPARE, POLY_B, 16'hFFFF, 16'h8000);
      send_word(cpsat_pkg::CMD_LOAD, POLY_A, 16'h0005, 16'h0005);
      send_word(cpsat_pkg::CMD_EVAL, POLY_A, 16'h0000, 16'h0000);
      // B alone: no collision
      send_word(cpsat_pkg::CMD_LOAD, POLY_B, 16'hFFFF, 16'hFFFF);
      send_word(cpsat_pkg::CMD_EVAL, POLY_B, 16'hFFFF, 16'hFFFF);
      // extreme coordinates and positions
      send_word(cpsat_pkg::CMD_LOAD, POLY_A, 16'h8000, 16'h8000);
      send_word(cpsat_pkg::CMD_LOAD, POLY_A, 16'h7FFF, 16'h8000);
      send_word(cpsat_pkg::CMD_LOAD, POLY_A, 16'h7FFF, 16'h7FFF);
      send_word(cpsat_pkg::CMD_POS,  POLY_A, 16'h7FFF, 16'h7FFF);
      send_word(cpsat_pkg::CMD_LOAD, POLY_B, 16'h8000, 16'h7FFF);
      send_word(cpsat_pkg::CMD_POS,  POLY_B, 16'h8000, 16'h8000);
      send_word(cpsat_pkg::CMD_EVAL, POLY_A, 16'h7FFF, 16'h8000);
      // overfill A with one repeated vertex: every edge has zero length and
      // the last load is dropped; B sits on the same point
      repeat (cpsat_pkg::MAX_VERTICES + 1)
         send_word(cpsat_pkg::CMD_LOAD, POLY_A, 16'h0064, 16'hFF9C);
      send_word(cpsat_pkg::CMD_LOAD, POLY_B, 16'h0064, 16'hFF9C);
      send_word(cpsat_pkg::CMD_EVAL, POLY_B, 16'h0000, 16'h0000);

      // random part: mostly complete polygon pairs, some noise
      while (sent_words < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) run_noise();
         else run_pair();
      end
      send_word(cpsat_pkg::CMD_EVAL, POLY_A, 16'h0000, 16'h0000);
      req_tvalid <= 1'b0;

      // drain, then give any stray result time to show up
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d words, %0d evaluates (%0d colliding, %0d with drops)",
               sent_words, sb.evals, sb.hits, sb.drops);
      $display("checked %0d results in %0d cycles", sb.results, cycles);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
src/cpsat_pkg.sv
src/cpsat_vram.sv
src/cpsat_proj.sv
src/convex_polygon_sat_collision_core.sv
src/cpsat_check.sv
test/tb.sv
